>>> design/rtcdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtcdt_pkg;

  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_GET  = 2'd2;

  // Phase numbers within one register access.
  localparam logic [5:0] PH_ADDR_FIRST = 6'd1;
  localparam logic [5:0] PH_ADDR_LAST  = 6'd25;
  localparam logic [5:0] PH_DATA_FIRST = 6'd26;
  localparam logic [5:0] PH_RD_LAST    = 6'd49;
  localparam logic [5:0] PH_WR_LAST    = 6'd50;
  localparam logic [5:0] PH_END_GET    = 6'd50;
  localparam logic [5:0] PH_END_SET    = 6'd51;

  localparam logic [3:0] LAST_WR_REG = 4'd8;
  localparam logic [3:0] LAST_RD_REG = 4'd6;
  localparam logic [3:0] REG_WP      = 4'd0;
  localparam logic [3:0] REG_YEAR    = 4'd7;
  localparam logic [3:0] REG_TRICKLE = 4'd8;

  localparam logic [7:0]  WP_VALUE      = 8'h00;
  localparam logic [7:0]  TRICKLE_VALUE = 8'hA5;
  localparam logic [11:0] YEAR_BASE     = 12'd2000;
  localparam logic [12:0] YEAR_RECIP    = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [6:0]  YEAR_DIV      = 7'd100;

  typedef struct packed {
    logic [1:0]  mode;
    logic        io_in;
    logic [5:0]  set_sec;
    logic [5:0]  set_min;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [2:0]  set_dotw;
    logic [13:0] set_year;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  pins;
    logic        busy_res;
    logic        read_valid;
    logic [7:0]  get_sec;
    logic [7:0]  get_min;
    logic [7:0]  get_hour;
    logic [7:0]  get_day;
    logic [7:0]  get_month;
    logic [7:0]  get_dotw;
    logic [11:0] get_year;
  } res_item_t;

  function automatic logic [7:0] wr_addr(input logic [3:0] idx);
    logic [7:0] a;
    a = 8'h00;
    case (idx)
      4'd0:    a = 8'h8E;
      4'd1:    a = 8'h80;
      4'd2:    a = 8'h82;
      4'd3:    a = 8'h84;
      4'd4:    a = 8'h86;
      4'd5:    a = 8'h88;
      4'd6:    a = 8'h8A;
      4'd7:    a = 8'h8C;
      4'd8:    a = 8'h90;
      default: a = 8'h00;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] rd_addr(input logic [3:0] idx);
    logic [7:0] a;
    a = 8'h00;
    case (idx)
      4'd0:    a = 8'h81;
      4'd1:    a = 8'h83;
      4'd2:    a = 8'h85;
      4'd3:    a = 8'h87;
      4'd4:    a = 8'h89;
      4'd5:    a = 8'h8B;
      4'd6:    a = 8'h8D;
      default: a = 8'h00;
    endcase
    return a;
  endfunction

  // Tens by reciprocal multiplication, exact for every 7-bit value.
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return 8'({4'd0, b[7:4]}) * 8'd10 + 8'({4'd0, b[3:0]});
  endfunction

endpackage

`default_nettype wire

>>> design/rtcdt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtcdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        io_in;
  logic [5:0]  set_sec;
  logic [5:0]  set_min;
  logic [4:0]  set_hour;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [2:0]  set_dotw;
  logic [13:0] set_year;

  modport source (output valid, mode, io_in, set_sec, set_min, set_hour, set_day,
                  set_month, set_dotw, set_year, input ready);
  modport sink (input valid, mode, io_in, set_sec, set_min, set_hour, set_day,
                set_month, set_dotw, set_year, output ready);
endinterface

interface rtcdt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pins;
  logic        busy_res;
  logic        read_valid;
  logic [7:0]  get_sec;
  logic [7:0]  get_min;
  logic [7:0]  get_hour;
  logic [7:0]  get_day;
  logic [7:0]  get_month;
  logic [7:0]  get_dotw;
  logic [11:0] get_year;

  modport source (output valid, pins, busy_res, read_valid, get_sec, get_min, get_hour,
                  get_day, get_month, get_dotw, get_year, input ready);
  modport sink (input valid, pins, busy_res, read_valid, get_sec, get_min, get_hour,
                get_day, get_month, get_dotw, get_year, output ready);
endinterface

`default_nettype wire

>>> design/rtcdt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcdt_seq
  import rtcdt_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        acc,
  input  in_item_t   item,
  output res_item_t  res
);

  logic [1:0] op_r, op_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [5:0] ph_r, ph_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] pins_r, pins_nxt;

  logic [7:0]  wv_r [6];
  logic [7:0]  rv_r [7];
  logic [13:0] year_r;
  logic [7:0]  yq_r;
  logic [7:0]  yb_r;
  logic [26:0] year_prod;
  logic [13:0] year_rem;

  logic       start, do_apply, wv_load, rv_we, done_get;
  logic [5:0] ph_last;
  logic [3:0] idx_last;
  logic [7:0] addr_byte, data_byte, tx_byte;
  logic [2:0] wv_sel;
  logic       tx_active, tx_release;

  assign year_prod = 27'(item.set_year) * 27'(YEAR_RECIP);
  assign year_rem  = year_r - 14'(yq_r) * 14'(YEAR_DIV);
  assign wv_sel    = idx_nxt[2:0] - 3'd1;

  always_comb begin
    addr_byte = (op_nxt == OP_SET) ? wr_addr(idx_nxt) : rd_addr(idx_nxt);
    case (idx_nxt)
      REG_WP:      data_byte = WP_VALUE;
      REG_YEAR:    data_byte = yb_r;
      REG_TRICKLE: data_byte = TRICKLE_VALUE;
      default:     data_byte = wv_r[wv_sel];
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    ph_nxt    = ph_r;
    sub_nxt   = sub_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pins_nxt  = pins_r;
    start     = 1'b0;
    do_apply  = 1'b0;
    wv_load   = 1'b0;
    rv_we     = 1'b0;
    done_get  = 1'b0;
    tx_active  = 1'b0;
    tx_release = 1'b0;
    tx_byte    = addr_byte;
    ph_last   = (op_r == OP_SET) ? PH_END_SET : PH_END_GET;
    idx_last  = (op_r == OP_SET) ? LAST_WR_REG : LAST_RD_REG;

    if (acc) begin
      if (op_r == OP_IDLE) begin
        if (item.mode == MODE_SET) begin
          op_nxt  = OP_SET;
          wv_load = 1'b1;
          start   = 1'b1;
        end else if (item.mode == MODE_GET) begin
          op_nxt = OP_GET;
          start  = 1'b1;
        end
        if (start) begin
          idx_nxt  = 4'd0;
          ph_nxt   = 6'd0;
          do_apply = 1'b1;
        end
      end else if (item.mode == MODE_TICK) begin
        if (ph_r != ph_last) begin
          ph_nxt   = ph_r + 6'd1;
          do_apply = 1'b1;
        end else if (idx_r == idx_last) begin
          done_get = (op_r == OP_GET);
          op_nxt   = OP_IDLE;
          idx_nxt  = 4'd0;
          ph_nxt   = 6'd0;
        end else begin
          idx_nxt  = idx_r + 4'd1;
          ph_nxt   = 6'd0;
          do_apply = 1'b1;
        end
      end
    end

    if (do_apply) begin
      // Bit and sub-phase counters track (phase - first phase of the byte) / 3 and % 3.
      if (ph_nxt == PH_ADDR_FIRST || ph_nxt == PH_DATA_FIRST) begin
        sub_nxt = 2'd0;
        bit_nxt = 3'd0;
      end else if (sub_r == 2'd2) begin
        sub_nxt = 2'd0;
        bit_nxt = bit_r + 3'd1;
      end else begin
        sub_nxt = sub_r + 2'd1;
      end

      if (ph_nxt == 6'd0) begin
        pins_nxt[0] = 1'b1;
        if (op_nxt == OP_GET) shift_nxt = 8'd0;
      end else if (ph_nxt <= PH_ADDR_LAST) begin
        tx_active  = 1'b1;
        tx_release = (ph_nxt == PH_ADDR_LAST);
        tx_byte    = addr_byte;
      end else if (op_nxt == OP_SET) begin
        if (ph_nxt <= PH_WR_LAST) begin
          tx_active  = 1'b1;
          tx_release = (ph_nxt == PH_WR_LAST);
          tx_byte    = data_byte;
        end else begin
          pins_nxt[0] = 1'b0;
        end
      end else if (ph_nxt <= PH_RD_LAST) begin
        case (sub_nxt)
          2'd0:    shift_nxt[bit_nxt] = item.io_in;
          2'd1:    pins_nxt[1] = 1'b1;
          default: pins_nxt[1] = 1'b0;
        endcase
      end else begin
        pins_nxt[0] = 1'b0;
        rv_we       = 1'b1;
      end

      if (tx_active) begin
        if (tx_release) begin
          pins_nxt[3] = 1'b0;
          pins_nxt[1] = 1'b0;
        end else begin
          case (sub_nxt)
            2'd0: begin
              pins_nxt[3] = 1'b1;
              pins_nxt[1] = 1'b0;
            end
            2'd1:    pins_nxt[2] = tx_byte[bit_nxt];
            default: pins_nxt[1] = 1'b1;
          endcase
        end
      end
    end
  end

  always_comb begin
    res.pins       = pins_nxt;
    res.busy_res   = (op_nxt != OP_IDLE);
    res.read_valid = done_get;
    res.get_sec    = done_get ? bcd_to_bin(rv_r[0]) : 8'd0;
    res.get_min    = done_get ? bcd_to_bin(rv_r[1]) : 8'd0;
    res.get_hour   = done_get ? bcd_to_bin(rv_r[2]) : 8'd0;
    res.get_day    = done_get ? bcd_to_bin(rv_r[3]) : 8'd0;
    res.get_month  = done_get ? bcd_to_bin(rv_r[4]) : 8'd0;
    res.get_dotw   = done_get ? bcd_to_bin(rv_r[5]) : 8'd0;
    res.get_year   = done_get ? YEAR_BASE + 12'(bcd_to_bin(rv_r[6])) : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_IDLE;
      idx_r   <= 4'd0;
      ph_r    <= 6'd0;
      sub_r   <= 2'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      pins_r  <= 4'd0;
    end else begin
      op_r    <= op_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      sub_r   <= sub_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // The year byte is needed only many phases after the start, so its
  // remainder and BCD conversion sit behind the quotient register.
  always_ff @(posedge clk) begin
    yb_r <= bin_to_bcd(year_rem[6:0]);
    if (wv_load) begin
      wv_r[0] <= bin_to_bcd({1'b0, item.set_sec});
      wv_r[1] <= bin_to_bcd({1'b0, item.set_min});
      wv_r[2] <= bin_to_bcd({2'b0, item.set_hour});
      wv_r[3] <= bin_to_bcd({2'b0, item.set_day});
      wv_r[4] <= bin_to_bcd({3'b0, item.set_month});
      wv_r[5] <= bin_to_bcd({4'b0, item.set_dotw});
      year_r  <= item.set_year;
      yq_r    <= year_prod[26:19];
    end
    if (rv_we) begin
      rv_r[idx_nxt[2:0]] <= shift_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/rtcdt_outreg.sv
`timescale 1ns / 1ps
`default_nettype none

module rtcdt_outreg
  import rtcdt_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  output logic         acc,
  input  res_item_t    res_in,
  rtcdt_out_if.source  out_ch
);

  logic      vld_r, vld_nxt;
  res_item_t res_r;

  // A new transaction is taken whenever the held result is empty or leaving.
  assign in_ready = !vld_r || out_ch.ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_in;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.pins       = res_r.pins;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.read_valid = res_r.read_valid;
  assign out_ch.get_sec    = res_r.get_sec;
  assign out_ch.get_min    = res_r.get_min;
  assign out_ch.get_hour   = res_r.get_hour;
  assign out_ch.get_day    = res_r.get_day;
  assign out_ch.get_month  = res_r.get_month;
  assign out_ch.get_dotw   = res_r.get_dotw;
  assign out_ch.get_year   = res_r.get_year;

endmodule

`default_nettype wire

>>> design/rtc_three_wire_datetime_master_top.sv
// Bit-level master for a three-wire real-time-clock link.
// Input channel in_ch: each transaction is one tick (mode 0) or a command
// (mode 1 set date and time, mode 2 get date and time) together with the
// sampled data pin level and the binary date fields. Commands are ignored
// while a sequence is running; a tick while idle changes nothing.
// Result channel out_ch: exactly one transaction per input transaction,
// carrying the pin levels after that tick (chip enable, serial clock, data
// out, drive enable), the busy flag and, on the tick that ends a get, the
// decoded date fields with read_valid set.
// Each accepted transaction's result is registered in the result register. One
// transaction is accepted every cycle; the only limit is the result
// register, and a new transaction is still taken in the cycle in which the
// held result is taken. If the receiver stalls, in_ch.ready drops and the
// held result stays put until it is taken.
// Reset leaves the sequencer idle with all pins low and the data line
// released; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module rtc_three_wire_datetime_master_top
  import rtcdt_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  rtcdt_in_if.sink    in_ch,
  rtcdt_out_if.source out_ch
);

  in_item_t  item;
  res_item_t res;
  logic      acc;
  logic      in_rdy;

  always_comb begin
    item.mode      = in_ch.mode;
    item.io_in     = in_ch.io_in;
    item.set_sec   = in_ch.set_sec;
    item.set_min   = in_ch.set_min;
    item.set_hour  = in_ch.set_hour;
    item.set_day   = in_ch.set_day;
    item.set_month = in_ch.set_month;
    item.set_dotw  = in_ch.set_dotw;
    item.set_year  = in_ch.set_year;
  end

  assign in_ch.ready = in_rdy;

  rtcdt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (item),
    .res   (res)
  );

  rtcdt_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .acc      (acc),
    .res_in   (res),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  a_valid_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.read_valid |-> !out_ch.busy_res)
    else $error("read_valid reported while still busy");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result register is stalled");

  a_idle_pins_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.busy_res |->
      (out_ch.pins[0] == 1'b0 && out_ch.pins[1] == 1'b0 && out_ch.pins[3] == 1'b0))
    else $error("link pins active while idle");

  a_read_valid_zero_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.read_valid |-> out_ch.get_year == 12'd0)
    else $error("date fields set without read_valid");
`endif

endmodule

`default_nettype wire
